// ===== design/rda_pkg.sv =====
// ----------------------------------------------------------------------------
// rda_pkg: shared types and constants for the rain drop animator
// Item structs, command codes, register indexes and control/status bundles.
// ----------------------------------------------------------------------------
package rda_pkg;

  localparam int STRIPS_DEF = 8;
  localparam int SLOTS_DEF  = 3;

  localparam int POS_W  = 10;
  localparam int CFG_W  = 10;
  localparam int CIDX_W = 1;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 10'd244;
  localparam logic [CFG_W-1:0] LEDS_RST      = 10'd60;
  localparam logic [2:0]       DROP_LEVEL    = 3'd2;

  localparam logic [CIDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_LEDS      = 1'd1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_END   = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic [9:0] random_value;
    logic [2:0] random_strip;
  } in_item_t;

  typedef struct packed {
    cmd_code_t  command;
    logic [2:0] strip_index;
    logic [9:0] pixel_position;
    logic [2:0] brightness;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_DRAW,
    ST_END
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic spawn;
    logic idx_clr;
    logic idx_inc;
    logic emit_clear;
    logic emit_draw;
    logic emit_end;
    logic step_pos;
    logic retire;
  } rda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_valid;
    logic cur_moves;
    logic idx_last;
    logic out_free;
  } rda_sts_t;

endpackage

// ===== design/rda_ctrl.sv =====
// ----------------------------------------------------------------------------
// rda_ctrl: tick sequencer
// Accepts an item, then walks the drop table one slot at a time and closes
// the tick with the end marker.
// ----------------------------------------------------------------------------
module rda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rda_pkg::rda_sts_t sts,
  output rda_pkg::rda_cmd_t cmd
);

  rda_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rda_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.spawn   = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = rda_pkg::ST_VISIT;
        end
      end
      rda_pkg::ST_VISIT: begin
        if (!sts.cur_valid) begin
          cmd.idx_inc = 1'b1;
          if (sts.idx_last) state_nxt = rda_pkg::ST_END;
        end else if (sts.out_free) begin
          cmd.emit_clear = 1'b1;
          if (sts.cur_moves) begin
            state_nxt = rda_pkg::ST_DRAW;
          end else begin
            cmd.retire  = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) state_nxt = rda_pkg::ST_END;
          end
        end
      end
      rda_pkg::ST_DRAW: begin
        if (sts.out_free) begin
          cmd.emit_draw = 1'b1;
          cmd.step_pos  = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_nxt     = sts.idx_last ? rda_pkg::ST_END : rda_pkg::ST_VISIT;
        end
      end
      rda_pkg::ST_END: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = rda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rda_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/rda_dp.sv =====
// ----------------------------------------------------------------------------
// rda_dp: drop table, settings and result register
// Holds per-slot valid bits and positions, the scan counters and the
// registered result item.
// ----------------------------------------------------------------------------
module rda_dp #(
  parameter int STRIPS = rda_pkg::STRIPS_DEF,
  parameter int SLOTS  = rda_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rda_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [rda_pkg::CFG_W-1:0]     cfg_wdata,
  input  rda_pkg::in_item_t             in_data,
  input  rda_pkg::rda_cmd_t             cmd,
  output rda_pkg::rda_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rda_pkg::out_item_t            out_data
);

  localparam int SW = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int LW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] STRIP_MAX = SW'(STRIPS - 1);
  localparam logic [LW-1:0] SLOT_MAX  = LW'(SLOTS - 1);

  logic [rda_pkg::CFG_W-1:0] thr_r, leds_r;
  logic                      valid_r [STRIPS][SLOTS];
  logic [rda_pkg::POS_W-1:0] pos_r   [STRIPS][SLOTS];
  logic [SW-1:0]             strip_r;
  logic [LW-1:0]             slot_r;
  logic                      out_valid_r;
  rda_pkg::out_item_t        out_data_r;

  logic                      spawn_ok;
  logic [SW-1:0]             sp_strip;
  logic [LW-1:0]             sp_slot;
  logic                      sp_found;
  logic [rda_pkg::POS_W-1:0] cur_pos;
  logic [rda_pkg::POS_W:0]   cur_inc;

  // settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= rda_pkg::THRESHOLD_RST;
      leds_r <= rda_pkg::LEDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rda_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata;
        rda_pkg::CFG_LEDS:      leds_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // first free slot of the requested strip
  always_comb begin
    sp_strip = in_data.random_strip[SW-1:0];
    sp_found = 1'b0;
    sp_slot  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!sp_found && !valid_r[sp_strip][i]) begin
        sp_found = 1'b1;
        sp_slot  = LW'(i);
      end
    end
    spawn_ok = (in_data.random_value < thr_r) &&
               (32'(in_data.random_strip) < STRIPS) && sp_found;
  end

  assign cur_pos = pos_r[strip_r][slot_r];
  assign cur_inc = {1'b0, cur_pos} + 11'd1;

  always_comb begin
    sts.cur_valid = valid_r[strip_r][slot_r];
    sts.cur_moves = cur_inc < {1'b0, leds_r};
    sts.idx_last  = (strip_r == STRIP_MAX) && (slot_r == SLOT_MAX);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // drop table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STRIPS; s++) begin
        for (int i = 0; i < SLOTS; i++) valid_r[s][i] <= 1'b0;
      end
    end else begin
      if (cmd.spawn && spawn_ok) begin
        valid_r[sp_strip][sp_slot] <= 1'b1;
      end
      if (cmd.retire) begin
        valid_r[strip_r][slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spawn && spawn_ok) begin
      pos_r[sp_strip][sp_slot] <= '0;
    end
    if (cmd.step_pos) begin
      pos_r[strip_r][slot_r] <= cur_inc[rda_pkg::POS_W-1:0];
    end
  end

  // scan counters, slot inner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r <= '0;
      slot_r  <= '0;
    end else if (cmd.idx_clr) begin
      strip_r <= '0;
      slot_r  <= '0;
    end else if (cmd.idx_inc) begin
      if (slot_r == SLOT_MAX) begin
        slot_r  <= '0;
        strip_r <= (strip_r == STRIP_MAX) ? '0 : strip_r + SW'(1);
      end else begin
        slot_r <= slot_r + LW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_clear || cmd.emit_draw || cmd.emit_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_clear) begin
      out_data_r.command        <= rda_pkg::CMD_CLEAR;
      out_data_r.strip_index    <= 3'(strip_r);
      out_data_r.pixel_position <= cur_pos;
      out_data_r.brightness     <= '0;
      out_data_r.last           <= 1'b0;
    end else if (cmd.emit_draw) begin
      out_data_r.command        <= rda_pkg::CMD_DRAW;
      out_data_r.strip_index    <= 3'(strip_r);
      out_data_r.pixel_position <= cur_inc[rda_pkg::POS_W-1:0];
      out_data_r.brightness     <= rda_pkg::DROP_LEVEL;
      out_data_r.last           <= 1'b0;
    end else if (cmd.emit_end) begin
      out_data_r.command        <= rda_pkg::CMD_END;
      out_data_r.strip_index    <= '0;
      out_data_r.pixel_position <= '0;
      out_data_r.brightness     <= '0;
      out_data_r.last           <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/rain_drop_animator.sv =====
// A tick's first result is registered from the visit state that follows the accept at best;
//   when the table is empty, every slot is visited and only the end marker goes.
// The sequencer visits one table slot a cycle, waiting for a free result register before
//   each command, adds a draw state per drop that moves and takes no new item until the end marker goes.
// Output back-pressure adds its own wait cycles; one result is held in a register.
// Reset (rst_n, synchronous): all slots empty, threshold 244, 60 LEDs per strip.
// ----------------------------------------------------------------------------
// rain_drop_animator: per-tick rain drop spawner and stepper
// Spawns at most one drop per tick and emits a clear for every active drop and
// a draw for each one that moves on, then an end-of-tick marker.
// ----------------------------------------------------------------------------
module rain_drop_animator #(
  parameter int STRIPS = rda_pkg::STRIPS_DEF,
  parameter int SLOTS  = rda_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // settings
  input  logic                       cfg_we,
  input  logic [rda_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rda_pkg::CFG_W-1:0]  cfg_wdata,
  // tick items in
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rda_pkg::in_item_t          in_data,
  // command items out
  output logic                       out_valid,
  input  logic                       out_ready,
  output rda_pkg::out_item_t         out_data
);

  // Controller owns sequencing only; the table, scan counters and the
  // result register sit in the datapath.
  rda_pkg::rda_cmd_t cmd;
  rda_pkg::rda_sts_t sts;

  rda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The spawn is applied in the accept cycle, so a fresh drop is stepped in
  // the same tick (cleared at 0, then drawn at 1 or retired).
  rda_dp #(
    .STRIPS (STRIPS),
    .SLOTS  (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/rda_tick_checker.sv =====
// ----------------------------------------------------------------------------
// rda_tick_checker: prediction and result checking for the rain drop animator
// Keeps its own drop table and settings, predicts the clear/draw/end commands
// of every accepted tick item and checks them in order against the block.
// ----------------------------------------------------------------------------
module rda_tick_checker
  import rda_pkg::*;
#(
  parameter int STRIPS = STRIPS_DEF,
  parameter int SLOTS  = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_data,
  output int                fails,
  output int                backlog
);

  logic [CFG_W-1:0] spawn_level;
  logic [CFG_W-1:0] strip_len;
  logic             drop_live [STRIPS][SLOTS];
  logic [POS_W-1:0] drop_row  [STRIPS][SLOTS];
  out_item_t        due_cmds[$];

  task automatic queue_cmd(input cmd_code_t code, input int strip, input int pos,
                           input logic [2:0] level, input logic fin);
    out_item_t c;
    c.command        = code;
    c.strip_index    = 3'(strip);
    c.pixel_position = POS_W'(pos);
    c.brightness     = level;
    c.last           = fin;
    due_cmds.push_back(c);
  endtask

  // spawn first, then step every live drop in strip/slot order
  task automatic predict_tick(input in_item_t it);
    int s;
    int k;
    int p;
    if (it.random_value < spawn_level && int'(it.random_strip) < STRIPS) begin
      for (k = 0; k < SLOTS; k++) begin
        if (!drop_live[it.random_strip][k]) begin
          drop_live[it.random_strip][k] = 1'b1;
          drop_row[it.random_strip][k]  = '0;
          break;
        end
      end
    end
    for (s = 0; s < STRIPS; s++) begin
      for (k = 0; k < SLOTS; k++) begin
        if (drop_live[s][k]) begin
          p = int'(drop_row[s][k]);
          queue_cmd(CMD_CLEAR, s, p, 3'd0, 1'b0);
          if (p + 1 < int'(strip_len)) begin
            drop_row[s][k] = POS_W'(p + 1);
            queue_cmd(CMD_DRAW, s, p + 1, DROP_LEVEL, 1'b0);
          end else begin
            drop_live[s][k] = 1'b0;
            drop_row[s][k]  = '0;
          end
        end
      end
    end
    queue_cmd(CMD_END, 0, 0, 3'd0, 1'b1);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int s;
    int k;
    if (!rst_n) begin
      fails       = 0;
      spawn_level = THRESHOLD_RST;
      strip_len   = LEDS_RST;
      for (s = 0; s < STRIPS; s++)
        for (k = 0; k < SLOTS; k++) begin
          drop_live[s][k] = 1'b0;
          drop_row[s][k]  = '0;
        end
      due_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: spawn_level = cfg_wdata;
          CFG_LEDS:      strip_len   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_tick(in_data);
      if (out_valid && out_ready) begin
        if (due_cmds.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected item: cmd=%0d strip=%0d pos=%0d bright=%0d last=%0d",
                     out_data.command, out_data.strip_index, out_data.pixel_position,
                     out_data.brightness, out_data.last);
        end else begin
          want = due_cmds.pop_front();
          if (out_data.command != want.command || out_data.strip_index != want.strip_index ||
              out_data.pixel_position != want.pixel_position ||
              out_data.brightness != want.brightness || out_data.last != want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: exp cmd=%0d strip=%0d pos=%0d bright=%0d last=%0d",
                       want.command, want.strip_index, want.pixel_position,
                       want.brightness, want.last);
              $display("          got cmd=%0d strip=%0d pos=%0d bright=%0d last=%0d",
                       out_data.command, out_data.strip_index, out_data.pixel_position,
                       out_data.brightness, out_data.last);
            end
          end
        end
      end
    end
    backlog = due_cmds.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top level for the rain drop animator
// Drives tick items and setting writes, stalls both channels in random bursts
// and leaves checking to rda_tick_checker; prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb;
  import rda_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  int fails;
  int backlog;

  // idling controls: percent chance of a burst, and a switch to turn it all off
  int   gap_pct   = 0;
  int   stall_pct = 0;
  logic calm      = 1'b0;
  int   hold_left = 0;

  always #1 clk = ~clk;

  rain_drop_animator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rda_tick_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fails     (fails),
    .backlog   (backlog)
  );

  // Result side back-pressure: a stall burst holds ready low until a random hold
  // counter, drawn from 0 to 16, has run down. Changes only on the falling edge, so the rising edge sees it stable.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (!calm && $urandom_range(99, 0) < stall_pct) begin
      out_ready = 1'b0;
      hold_left = $urandom_range(16, 0);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Offer one tick item, possibly after an idle burst, and hold it until taken.
  // Called and returns on a falling edge; valid stays high into the next item
  // when no gap is drawn.
  task automatic push_tick(input logic [9:0] value, input logic [2:0] strip);
    int gap;
    if (!calm && $urandom_range(99, 0) < gap_pct) begin
      gap      = $urandom_range(17, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.random_value = value;
    in_data.random_strip = strip;
    in_valid             = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted command has come back, then
  // give the block a further wait to fall idle.
  task automatic settle();
    in_valid = 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // Settings are only written while the block is idle.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] leds;
    logic [9:0]       val;
    logic [2:0]       strip;
    int               ph;
    int               n;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed part ---
    gap_pct   = 20;
    stall_pct = 15;

    // short strips, everything spawns: fill strip 0 and keep hitting it as drops retire;
    // the top value equals the threshold and so must not spawn
    write_reg(CFG_THRESHOLD, 10'd1023);
    write_reg(CFG_LEDS, 10'd3);
    push_tick(10'd0, 3'd0);
    push_tick(10'd1, 3'd0);
    push_tick(10'd2, 3'd0);
    push_tick(10'd3, 3'd0);
    push_tick(10'd1023, 3'd0);
    push_tick(10'd1022, 3'd7);
    push_tick(10'd512, 3'd5);
    push_tick(10'd0, 3'd7);
    push_tick(10'd0, 3'd7);
    push_tick(10'd0, 3'd7);

    // zero threshold never spawns; one LED per strip retires drops in flight
    settle();
    write_reg(CFG_THRESHOLD, 10'd0);
    write_reg(CFG_LEDS, 10'd1);
    push_tick(10'd0, 3'd3);
    push_tick(10'd1023, 3'd6);

    // no LEDs at all: each new drop is cleared and retired at once
    settle();
    write_reg(CFG_THRESHOLD, 10'd1000);
    write_reg(CFG_LEDS, 10'd0);
    push_tick(10'd999, 3'd1);
    push_tick(10'd1000, 3'd2);
    push_tick(10'd682, 3'd2);
    push_tick(10'd341, 3'd5);

    // back to the reset settings, either side of the threshold
    settle();
    write_reg(CFG_THRESHOLD, THRESHOLD_RST);
    write_reg(CFG_LEDS, LEDS_RST);
    push_tick(10'd243, 3'd0);
    push_tick(10'd244, 3'd1);

    // longest strip
    settle();
    write_reg(CFG_THRESHOLD, 10'd500);
    write_reg(CFG_LEDS, 10'd1023);
    push_tick(10'd499, 3'd4);
    push_tick(10'd500, 3'd4);

    // --- random part: six phases of 42 ticks, each with fresh settings ---
    strip = 3'd0;
    for (ph = 0; ph < 6; ph++) begin
      settle();
      case ($urandom_range(7, 0))
        0:       thr = 10'd0;
        1:       thr = 10'd1023;
        2:       thr = 10'd1000;
        default: thr = 10'($urandom_range(1023, 200));
      endcase
      case ($urandom_range(7, 0))
        0:       leds = 10'd0;
        1:       leds = 10'd1;
        2:       leds = 10'd1023;
        3:       leds = 10'd2;
        default: leds = 10'($urandom_range(24, 3));
      endcase
      write_reg(CFG_THRESHOLD, thr);
      write_reg(CFG_LEDS, leds);

      // the last phase runs flat out on both sides
      calm      = (ph == 5);
      gap_pct   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 2);
      stall_pct = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 2);

      for (n = 0; n < 42; n++) begin
        // values near the threshold and at the range ends turn up often
        case ($urandom_range(7, 0))
          0:       val = 10'd0;
          1:       val = 10'd1023;
          2:       val = thr - 10'd1;
          3:       val = thr;
          default: val = 10'($urandom_range(1023, 0));
        endcase
        // sometimes hammer the same strip so it fills up
        if ($urandom_range(3, 0) != 0)
          strip = 3'($urandom_range(7, 0));
        push_tick(val, strip);
      end
    end

    settle();
    if (fails == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // watchdog: well beyond the slowest legal run
  initial begin
    #2500000;
    $display("tb failed");
    $finish;
  end

endmodule
